/* hw/rtl/signed_int_to_decimal_ascii_core_macros.svh */
// Assertion macros shared by the signed integer to decimal text core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SITDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sitda_pkg.sv */
// Package with constants and types shared by the decimal text core.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  localparam int NUM_W    = 32;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int IDX_W    = $clog2(DIGITS);
  localparam int CHUNK    = 8;
  localparam int CHAR_W   = 7;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } sitda_word_t;

endpackage

`default_nettype wire

/* hw/rtl/sitda_dabble_stage.sv */
// One pipeline stage that shifts a chunk of binary bits into the decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module sitda_dabble_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire sitda_pkg::sitda_word_t in_word,
  output logic                     in_ready,
  output logic                     out_valid,
  output sitda_pkg::sitda_word_t   out_word,
  input  wire logic                out_ready
);
  import sitda_pkg::*;

  sitda_word_t word_next;

  always_comb begin
    word_next = in_word;
    for (int j = 0; j < CHUNK; j++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (word_next.bcd[4*d +: 4] >= 4'd5) begin
          word_next.bcd[4*d +: 4] = word_next.bcd[4*d +: 4] + 4'd3;
        end
      end
      word_next.bcd = {word_next.bcd[BCD_W-2:0], word_next.bin[NUM_W-1]};
      word_next.bin = {word_next.bin[NUM_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sitda_serializer.sv */
// Output stage that emits the sign and the significant digits one per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_serializer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire sitda_pkg::sitda_word_t        in_word,
  output logic                               in_ready,
  output logic                               strobe,
  output logic [sitda_pkg::CHAR_W-1:0]       character,
  output logic                               final_char
);
  import sitda_pkg::*;

  logic                        active;
  logic                        neg;
  logic [IDX_W-1:0]            idx;
  logic [DIGITS-1:0][3:0]      digits;
  logic [IDX_W-1:0]            lead;
  logic                        last_now;

  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (in_word.bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign last_now = active && !neg && (idx == '0);
  assign in_ready = !active || last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (in_ready) begin
        active <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      neg    <= in_word.neg;
      idx    <= lead;
      digits <= in_word.bcd;
    end else if (active) begin
      if (neg) begin
        neg <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (neg) begin
        character  <= CHAR_MINUS;
        final_char <= 1'b0;
      end else begin
        character  <= CHAR_ZERO + {3'b000, digits[idx]};
        final_char <= (idx == '0);
      end
    end
  end

  `SITDA_ASSERT_NOW(a_minus_not_final, clk, rst, strobe && (character == CHAR_MINUS),
                    !final_char, "Minus sign marked as last character.")
  `SITDA_ASSERT_NOW(a_char_range, clk, rst, strobe && (character != CHAR_MINUS),
                    (character >= CHAR_ZERO) && (character <= CHAR_NINE),
                    "Character is not a decimal digit.")
  `SITDA_ASSERT_NEXT(a_text_contiguous, clk, rst, strobe && !final_char, strobe,
                     "Gap inside the text of one number.")

endmodule

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii_core.sv */
// Top level of the signed 32-bit integer to decimal ASCII text core.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start high, busy low      number (32-bit signed)
//   result    out        strobe, one cycle each    character (7 bits), final_char
//
// A request passes through the sign stage and the digit conversion stages before
// the output stage registers its first character. The output stage emits one
// character per cycle, the sign of a negative number and then the significant
// digits; that stage sets the sustained rate. Reset is synchronous and clears all
// valid bits. Busy rises only when the pipeline backs up behind the output stage;
// the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [sitda_pkg::NUM_W-1:0] number,
  output logic                                 busy,
  output logic                                 strobe,
  output logic [sitda_pkg::CHAR_W-1:0]         character,
  output logic                                 final_char
);
  import sitda_pkg::*;

  localparam int STAGES = NUM_W / CHUNK;

  logic        v0;
  sitda_word_t w0;
  logic        accept;

  logic        st_valid [STAGES+1];
  sitda_word_t st_word  [STAGES+1];
  logic        st_ready [STAGES+1];

  assign busy   = v0 && !st_ready[0];
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (!busy) begin
      v0 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w0.neg <= number[NUM_W-1];
      w0.bin <= number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number)) : NUM_W'(number);
      w0.bcd <= '0;
    end
  end

  assign st_valid[0] = v0;
  assign st_word[0]  = w0;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    sitda_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_word   (st_word[g]),
      .in_ready  (st_ready[g]),
      .out_valid (st_valid[g+1]),
      .out_word  (st_word[g+1]),
      .out_ready (st_ready[g+1])
    );
  end

  sitda_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid[STAGES]),
    .in_word    (st_word[STAGES]),
    .in_ready   (st_ready[STAGES]),
    .strobe     (strobe),
    .character  (character),
    .final_char (final_char)
  );

  `SITDA_ASSERT_NEXT(a_accept_loads, clk, rst, accept, v0, "Accepted request did not enter the sign stage.")
  `SITDA_ASSERT_NEXT(a_busy_holds, clk, rst, busy, v0 && $stable(w0), "Stalled sign stage lost its request.")

endmodule

`default_nettype wire

/* bench/decimal_text_checker.sv */
// Checker that predicts and compares the decimal text of each accepted request.
`timescale 1ns / 1ps

module decimal_text_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [sitda_pkg::NUM_W-1:0]      number,
  input  logic                             strobe,
  input  logic [sitda_pkg::CHAR_W-1:0]     character,
  input  logic                             final_char,
  output int                               fail_count,
  output int                               outstanding
);

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  text_char_t expected_text[$];

  function automatic void queue_decimal_text(input logic [sitda_pkg::NUM_W-1:0] value);
    logic [sitda_pkg::NUM_W-1:0] mag;
    logic [3:0]                  digit_buf [sitda_pkg::DIGITS];
    int                          count;
    text_char_t                  c;
    count = 0;
    if (value[sitda_pkg::NUM_W-1]) begin
      c.code = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
      mag = -value;
    end else begin
      mag = value;
    end
    if (mag == '0) begin
      c.code = sitda_pkg::CHAR_ZERO;
      c.last = 1'b1;
      expected_text.push_back(c);
      return;
    end
    while (mag != '0) begin
      digit_buf[count] = 4'(mag % 10);
      count++;
      mag = mag / 10;
    end
    while (count > 0) begin
      count--;
      c.code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit_buf[count]);
      c.last = (count == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      expected_text.delete();
    end else begin
      if (start && !busy) begin
        queue_decimal_text(number);
      end
      if (strobe) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %h final %b",
                   $time, character, final_char);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (character !== want.code) begin
            $display("%0t: character mismatch, expected %h, actual %h",
                     $time, want.code, character);
            fail_count++;
          end
          if (final_char !== want.last) begin
            $display("%0t: final_char mismatch, expected %b, actual %b",
                     $time, want.last, final_char);
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_text.size();
  end

endmodule

/* bench/tb.sv */
// Testbench top that drives numbers into the decimal text core and gives the verdict.
`timescale 1ns / 1ps

module tb;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic signed [sitda_pkg::NUM_W-1:0]  number;
  logic                                busy;
  logic                                strobe;
  logic [sitda_pkg::CHAR_W-1:0]        character;
  logic                                final_char;
  int                                  fail_count;
  int                                  outstanding;

  signed_int_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .number     (number),
    .busy       (busy),
    .strobe     (strobe),
    .character  (character),
    .final_char (final_char)
  );

  decimal_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .number      (number),
    .strobe      (strobe),
    .character   (character),
    .final_char  (final_char),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_number(input logic [sitda_pkg::NUM_W-1:0] value, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 99) < 34) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start  <= 1'b0;
      number <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [sitda_pkg::NUM_W-1:0] pick_number();
    int unsigned lo;
    int unsigned hi;
    int unsigned len;
    logic [sitda_pkg::NUM_W-1:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    if ($urandom_range(0, 19) == 0) return '0;
    len = $urandom_range(1, 10);
    lo = 1;
    repeat (len - 1) lo = lo * 10;
    hi = (len == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
    v = $urandom_range(hi, lo);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  logic [sitda_pkg::NUM_W-1:0] directed [$];
  bit                          steady;

  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    number = '0;
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd5, 32'd7,
                 32'd1000, -32'sd100000, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i], 1'b1);
    drain_results();

    for (int i = 0; i < 220; i++) begin
      steady = (i >= 80 && i < 140);
      if (i == 150) drain_results();
      send_number(pick_number(), !steady);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
